/* rtl/tod_pkg.sv */
// Shared types, constants and helpers for the time-of-day arithmetic unit.
package tod_pkg;

    // Operation codes
    localparam logic [3:0] FN_VALIDATE = 4'd0;
    localparam logic [3:0] FN_TO_SECS  = 4'd1;
    localparam logic [3:0] FN_FROM_SECS = 4'd2;
    localparam logic [3:0] FN_ADD      = 4'd3;
    localparam logic [3:0] FN_SUB      = 4'd4;
    localparam logic [3:0] FN_DURATION = 4'd5;
    localparam logic [3:0] FN_EQ       = 4'd6;
    localparam logic [3:0] FN_NEQ      = 4'd7;
    localparam logic [3:0] FN_LT       = 4'd8;
    localparam logic [3:0] FN_GT       = 4'd9;

    localparam logic [16:0] DAY_SECS   = 17'd86400;
    localparam logic [18:0] DAY2_SECS  = 19'd172800;
    localparam logic [18:0] DAY3_SECS  = 19'd259200;
    localparam logic [11:0] HOUR_SECS  = 12'd3600;
    localparam logic [5:0]  MIN_SECS   = 6'd60;
    localparam logic [5:0]  MAX_HOUR   = 6'd23;
    localparam logic [5:0]  MAX_MIN    = 6'd59;

    // 86400 = 675 << 7; floor(2^35 / 675)
    localparam logic [9:0]  DIV_675    = 10'd675;
    localparam logic [25:0] RECIP_675  = 26'd50903316;
    // floor(2^27 / 3600) and floor(2^17 / 60)
    localparam logic [15:0] RECIP_HOUR = 16'd37282;
    localparam logic [11:0] RECIP_MIN  = 12'd2184;

    typedef struct packed {
        logic [3:0]  func;
        logic [5:0]  hour_a;
        logic [5:0]  minute_a;
        logic [5:0]  second_a;
        logic [5:0]  hour_b;
        logic [5:0]  minute_b;
        logic [5:0]  second_b;
        logic [31:0] seconds_in;
    } t_cmd;

    typedef struct packed {
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic [17:0] seconds_out;
        logic        flag_out;
    } t_res;

    // Front end to reducer
    typedef struct packed {
        logic [3:0]  func;
        logic        flag;
        logic [17:0] sec_direct;
        logic [17:0] ta;
        logic [16:0] nr;
    } t_fr;

    // Reducer through split stages
    typedef struct packed {
        logic        is_time;
        logic        flag;
        logic [17:0] sec_direct;
        logic [16:0] v;
    } t_rd;

    function automatic logic [17:0] tod_secs(input logic [5:0] h, input logic [5:0] m,
                                             input logic [5:0] s);
        tod_secs = 18'(h) * 18'(HOUR_SECS) + 18'(m) * 18'(MIN_SECS) + 18'(s);
    endfunction

endpackage

/* rtl/time_of_day_arithmetic_unit_top.sv */
// Top level of the time-of-day arithmetic unit.
//
// Usage: present an item on i_cmd and raise start; it is taken at any rising
// edge where busy is low. busy is high during reset and until the first edge
// after it, then stays low, so one item can be taken every cycle. Each item
// gives exactly one result on o_result, marked by o_strobe for one cycle, in
// issue order. There is no way to hold results off: the receiver must capture
// o_result whenever o_strobe is high. The register stages of the pipeline are
// two for the front end (time-to-seconds, then seconds_in mod 86400 by a
// reciprocal multiply with one correction step, compares and duration), one
// to fold the from/add/sub value into one day, and four to split seconds of
// day into hours (reciprocal multiply, correct) and minutes/seconds (same
// again). Fields an operation does not define come out as zero; unknown func
// codes give an all-zero result.
module time_of_day_arithmetic_unit_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tod_pkg::t_cmd    i_cmd,
    output logic             o_strobe,
    output tod_pkg::t_res    o_result
);

    logic             r_run;
    logic             w_take;
    logic             w_fr_vld;
    tod_pkg::t_fr     w_fr;
    logic             w_rd_vld;
    tod_pkg::t_rd     w_rd;

    // busy only while coming out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy   = !r_run;
    assign w_take = start && !busy;

    tod_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_take),
        .i_cmd   (i_cmd),
        .o_vld   (w_fr_vld),
        .o_fr    (w_fr)
    );

    tod_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_fr_vld),
        .i_fr    (w_fr),
        .o_vld   (w_rd_vld),
        .o_rd    (w_rd)
    );

    tod_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_rd_vld),
        .i_rd    (w_rd),
        .o_vld   (o_strobe),
        .o_res   (o_result)
    );

endmodule

/* rtl/tod_front.sv */
// Front end: time-to-seconds, seconds_in mod one day, compares and duration.
module tod_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  tod_pkg::t_cmd    i_cmd,
    output logic             o_vld,
    output tod_pkg::t_fr     o_fr
);

    // stage 1
    logic             r_s1_vld;
    tod_pkg::t_cmd    r_s1_cmd;
    logic [17:0]      r_s1_ta;
    logic [17:0]      r_s1_tb;
    logic [15:0]      r_s1_q;
    logic [50:0]      w_prod;

    // stage 2
    logic             r_s2_vld;
    tod_pkg::t_fr     r_s2_fr;
    tod_pkg::t_fr     n_s2_fr;
    logic [24:0]      w_x;
    logic [24:0]      w_qm;
    logic [10:0]      w_rem1;
    logic [9:0]       w_rem;
    logic [19:0]      w_wrap;
    logic [17:0]      w_dur;

    // quotient estimate of (n >> 7) / 675, low by at most one
    assign w_prod = 51'(i_cmd.seconds_in[31:7]) * 51'(tod_pkg::RECIP_675);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
        end
        r_s1_cmd <= i_cmd;
        r_s1_ta  <= tod_pkg::tod_secs(i_cmd.hour_a, i_cmd.minute_a, i_cmd.second_a);
        r_s1_tb  <= tod_pkg::tod_secs(i_cmd.hour_b, i_cmd.minute_b, i_cmd.second_b);
        r_s1_q   <= w_prod[50:35];
    end

    assign w_x    = r_s1_cmd.seconds_in[31:7];
    assign w_qm   = 25'(r_s1_q) * 25'(tod_pkg::DIV_675);
    assign w_rem1 = 11'(w_x - w_qm);
    assign w_rem  = (w_rem1 >= 11'(tod_pkg::DIV_675)) ?
                    10'(w_rem1 - 11'(tod_pkg::DIV_675)) : w_rem1[9:0];

    // A later than B: a day is added, wrapping to 18 bits for bad fields
    assign w_wrap = 20'(tod_pkg::DAY_SECS) + 20'(r_s1_tb) - 20'(r_s1_ta);
    assign w_dur  = (r_s1_ta > r_s1_tb) ? w_wrap[17:0] : (r_s1_tb - r_s1_ta);

    always_comb begin
        n_s2_fr.func       = r_s1_cmd.func;
        n_s2_fr.ta         = r_s1_ta;
        n_s2_fr.nr         = {w_rem, r_s1_cmd.seconds_in[6:0]};
        n_s2_fr.flag       = 1'b0;
        n_s2_fr.sec_direct = '0;
        case (r_s1_cmd.func)
            tod_pkg::FN_VALIDATE: begin
                n_s2_fr.flag = (r_s1_cmd.hour_a <= tod_pkg::MAX_HOUR) &&
                               (r_s1_cmd.minute_a <= tod_pkg::MAX_MIN) &&
                               (r_s1_cmd.second_a <= tod_pkg::MAX_MIN);
            end
            tod_pkg::FN_TO_SECS: begin
                n_s2_fr.sec_direct = r_s1_ta;
            end
            tod_pkg::FN_DURATION: begin
                n_s2_fr.sec_direct = w_dur;
            end
            tod_pkg::FN_EQ: begin
                n_s2_fr.flag = (r_s1_cmd.hour_a == r_s1_cmd.hour_b) &&
                               (r_s1_cmd.minute_a == r_s1_cmd.minute_b) &&
                               (r_s1_cmd.second_a == r_s1_cmd.second_b);
            end
            tod_pkg::FN_NEQ: begin
                n_s2_fr.flag = (r_s1_cmd.hour_a != r_s1_cmd.hour_b) ||
                               (r_s1_cmd.minute_a != r_s1_cmd.minute_b) ||
                               (r_s1_cmd.second_a != r_s1_cmd.second_b);
            end
            tod_pkg::FN_LT: begin
                n_s2_fr.flag = (r_s1_ta < r_s1_tb);
            end
            tod_pkg::FN_GT: begin
                n_s2_fr.flag = (r_s1_ta > r_s1_tb);
            end
            default: begin
                n_s2_fr.flag = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_fr <= n_s2_fr;
    end

    assign o_vld = r_s2_vld;
    assign o_fr  = r_s2_fr;

endmodule

/* rtl/tod_reduce.sv */
// Reducer: forms the from/add/sub seconds value and folds it into one day.
module tod_reduce (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  tod_pkg::t_fr     i_fr,
    output logic             o_vld,
    output tod_pkg::t_rd     o_rd
);

    logic             r_vld;
    tod_pkg::t_rd     r_rd;
    tod_pkg::t_rd     n_rd;
    logic [18:0]      w_base;
    logic [18:0]      w_sub;

    // base stays below four days, so one of three offsets folds it
    always_comb begin
        case (i_fr.func)
            tod_pkg::FN_ADD: w_base = 19'(i_fr.ta) + 19'(i_fr.nr);
            tod_pkg::FN_SUB: w_base = 19'(i_fr.ta) + 19'(tod_pkg::DAY_SECS) - 19'(i_fr.nr);
            default:         w_base = 19'(i_fr.nr);
        endcase
        if (w_base >= tod_pkg::DAY3_SECS) begin
            w_sub = tod_pkg::DAY3_SECS;
        end else if (w_base >= tod_pkg::DAY2_SECS) begin
            w_sub = tod_pkg::DAY2_SECS;
        end else if (w_base >= 19'(tod_pkg::DAY_SECS)) begin
            w_sub = 19'(tod_pkg::DAY_SECS);
        end else begin
            w_sub = '0;
        end
        n_rd.v          = 17'(w_base - w_sub);
        n_rd.flag       = i_fr.flag;
        n_rd.sec_direct = i_fr.sec_direct;
        n_rd.is_time    = (i_fr.func == tod_pkg::FN_FROM_SECS) ||
                          (i_fr.func == tod_pkg::FN_ADD) ||
                          (i_fr.func == tod_pkg::FN_SUB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_rd <= n_rd;
    end

    assign o_vld = r_vld;
    assign o_rd  = r_rd;

endmodule

/* rtl/tod_split.sv */
// Split: seconds of day into hours, minutes, seconds; result assembly.
module tod_split (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  tod_pkg::t_rd     i_rd,
    output logic             o_vld,
    output tod_pkg::t_res    o_res
);

    // stage 4: hour estimate
    logic             r4_vld;
    tod_pkg::t_rd     r4_rd;
    logic [4:0]       r4_hq;
    logic [31:0]      w_ph;

    // stage 5: hour correction
    logic             r5_vld;
    tod_pkg::t_rd     r5_rd;
    logic [4:0]       r5_h;
    logic [11:0]      r5_rem;
    logic [16:0]      w_hm;
    logic [12:0]      w_hr;
    logic [4:0]       n5_h;
    logic [11:0]      n5_rem;

    // stage 6: minute estimate
    logic             r6_vld;
    tod_pkg::t_rd     r6_rd;
    logic [4:0]       r6_h;
    logic [11:0]      r6_rem;
    logic [5:0]       r6_mq;
    logic [22:0]      w_pm;

    // stage 7: minute correction, output
    logic             r7_vld;
    tod_pkg::t_res    r7_res;
    tod_pkg::t_res    n7_res;
    logic [11:0]      w_mm;
    logic [6:0]       w_sr;
    logic [5:0]       n7_m;
    logic [5:0]       n7_s;

    assign w_ph = 32'(i_rd.v) * 32'(tod_pkg::RECIP_HOUR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= i_vld;
        end
        r4_rd <= i_rd;
        r4_hq <= w_ph[31:27];
    end

    assign w_hm = 17'(r4_hq) * 17'(tod_pkg::HOUR_SECS);
    assign w_hr = 13'(r4_rd.v - w_hm);

    always_comb begin
        if (w_hr >= 13'(tod_pkg::HOUR_SECS)) begin
            n5_h   = r4_hq + 5'd1;
            n5_rem = 12'(w_hr - 13'(tod_pkg::HOUR_SECS));
        end else begin
            n5_h   = r4_hq;
            n5_rem = w_hr[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_rd  <= r4_rd;
        r5_h   <= n5_h;
        r5_rem <= n5_rem;
    end

    assign w_pm = 23'(r5_rem) * 23'(tod_pkg::RECIP_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_rd  <= r5_rd;
        r6_h   <= r5_h;
        r6_rem <= r5_rem;
        r6_mq  <= w_pm[22:17];
    end

    assign w_mm = 12'(r6_mq) * 12'(tod_pkg::MIN_SECS);
    assign w_sr = 7'(r6_rem - w_mm);

    always_comb begin
        if (w_sr >= 7'(tod_pkg::MIN_SECS)) begin
            n7_m = r6_mq + 6'd1;
            n7_s = 6'(w_sr - 7'(tod_pkg::MIN_SECS));
        end else begin
            n7_m = r6_mq;
            n7_s = w_sr[5:0];
        end
        // fields an operation does not define read as zero
        n7_res.hour_out    = r6_rd.is_time ? r6_h : '0;
        n7_res.minute_out  = r6_rd.is_time ? n7_m : '0;
        n7_res.second_out  = r6_rd.is_time ? n7_s : '0;
        n7_res.seconds_out = r6_rd.is_time ? {1'b0, r6_rd.v} : r6_rd.sec_direct;
        n7_res.flag_out    = r6_rd.flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
        r7_res <= n7_res;
    end

    assign o_vld = r7_vld;
    assign o_res = r7_res;

endmodule

/* rtl/tod_chk.sv */
// Port-level checks for the time-of-day arithmetic unit, bound to the top.
module tod_chk (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             o_strobe,
    input  tod_pkg::t_res    o_result
);

    // every taken item comes back on o_strobe once through the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_strobe)
        else $error("taken item gave no result after 7 cycles");

    // no result without a matching item taken earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 7))
        else $error("result without a matching item");

    // time fields always form a legal time of day
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.hour_out <= 5'd23) && (o_result.minute_out <= 6'd59) &&
                     (o_result.second_out <= 6'd59))
        else $error("time fields out of range");

    // a produced time agrees with its seconds count
    a_time_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.hour_out != 5'd0 || o_result.minute_out != 6'd0 ||
                      o_result.second_out != 6'd0)) |->
        (o_result.seconds_out == 18'(o_result.hour_out) * 18'd3600 +
                                 18'(o_result.minute_out) * 18'd60 +
                                 18'(o_result.second_out)))
        else $error("time fields disagree with seconds_out");

endmodule

bind time_of_day_arithmetic_unit_top tod_chk u_chk (.*);

/* bench/tb_time_of_day_arithmetic_unit_top.sv */
// Self-checking testbench for the time-of-day arithmetic unit top level.
`timescale 1ns / 1ps

module tb_time_of_day_arithmetic_unit_top;

    // Seconds arithmetic, kept local so the prediction is independent of the RTL.
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned HOUR_LIMIT    = 23;
    localparam int unsigned MIN_LIMIT     = 59;

    // Highest defined op code; codes above it must give an all-zero result.
    localparam logic [3:0]  FN_LAST       = tod_pkg::FN_GT;
    localparam logic [3:0]  FN_CODE_MAX   = 4'hF;

    // Stall watchdog: cycles with neither an accepted item nor a result.
    localparam int          STALL_LIMIT   = 2000;
    // Cycles waited after the last result; pipeline is 7 stages deep.
    localparam int          TAIL_CYCLES   = 16;
    localparam int          RANDOM_ITEMS  = 430;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    tod_pkg::t_cmd  i_cmd;
    logic           o_strobe;
    tod_pkg::t_res  o_result;

    // Results still owed by the pipeline, oldest first.
    tod_pkg::t_res  pending_results[$];
    int    error_count;
    int    stall_cycles;
    // Items left in the current burst of the sender.
    int    burst_left;

    time_of_day_arithmetic_unit_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Seconds since midnight, taken from the fields as given (no range check).
    function automatic int unsigned hms_to_secs(input logic [5:0] h, input logic [5:0] m,
                                                input logic [5:0] s);
        hms_to_secs = int'(h) * SECS_PER_HOUR + int'(m) * SECS_PER_MIN + int'(s);
    endfunction

    // Splits an already reduced seconds-of-day value into a time result.
    function automatic tod_pkg::t_res secs_to_time(input int unsigned day_secs);
        tod_pkg::t_res r;
        int unsigned hh;
        int unsigned mm;
        int unsigned ss;
        r  = '0;
        hh = day_secs / SECS_PER_HOUR;
        mm = (day_secs % SECS_PER_HOUR) / SECS_PER_MIN;
        ss = day_secs % SECS_PER_MIN;
        r.hour_out    = hh[4:0];
        r.minute_out  = mm[5:0];
        r.second_out  = ss[5:0];
        r.seconds_out = day_secs[17:0];
        return r;
    endfunction

    function automatic tod_pkg::t_res tod_predict(input tod_pkg::t_cmd c);
        tod_pkg::t_res     r;
        int unsigned       ta;
        int unsigned       tb;
        int unsigned       gap;
        longint unsigned   sum;
        r   = '0;
        ta  = hms_to_secs(c.hour_a, c.minute_a, c.second_a);
        tb  = hms_to_secs(c.hour_b, c.minute_b, c.second_b);
        sum = longint'(ta) + longint'(c.seconds_in);
        case (c.func)
            tod_pkg::FN_VALIDATE: begin
                r.flag_out = (c.hour_a <= HOUR_LIMIT && c.minute_a <= MIN_LIMIT &&
                              c.second_a <= MIN_LIMIT);
            end
            tod_pkg::FN_TO_SECS: begin
                r.seconds_out = ta[17:0];
            end
            tod_pkg::FN_FROM_SECS: begin
                r = secs_to_time(c.seconds_in % SECS_PER_DAY);
            end
            tod_pkg::FN_ADD: begin
                r = secs_to_time(int'(sum % SECS_PER_DAY));
            end
            tod_pkg::FN_SUB: begin
                // amount is folded into one day first, so the difference never goes negative
                r = secs_to_time((ta + SECS_PER_DAY - c.seconds_in % SECS_PER_DAY)
                                 % SECS_PER_DAY);
            end
            tod_pkg::FN_DURATION: begin
                // A later than B wraps through midnight; with out-of-range fields
                // this can go below zero and wraps to 18 bits
                if (ta > tb) begin
                    gap = SECS_PER_DAY - ta + tb;
                end else begin
                    gap = tb - ta;
                end
                r.seconds_out = gap[17:0];
            end
            tod_pkg::FN_EQ: begin
                r.flag_out = (c.hour_a == c.hour_b && c.minute_a == c.minute_b &&
                              c.second_a == c.second_b);
            end
            tod_pkg::FN_NEQ: begin
                r.flag_out = (c.hour_a != c.hour_b || c.minute_a != c.minute_b ||
                              c.second_a != c.second_b);
            end
            tod_pkg::FN_LT: begin
                r.flag_out = (ta < tb);
            end
            tod_pkg::FN_GT: begin
                r.flag_out = (ta > tb);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // All signals are sampled at the clock edge, before the DUT's updates land.
    // Results are checked before the item accepted at the same edge is queued.
    always @(posedge i_clk) begin
        tod_pkg::t_res want;
        if (o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding: %h", o_result);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("hour_out",    want.hour_out,    o_result.hour_out);
                check_field("minute_out",  want.minute_out,  o_result.minute_out);
                check_field("second_out",  want.second_out,  o_result.second_out);
                check_field("seconds_out", want.seconds_out, o_result.seconds_out);
                check_field("flag_out",    want.flag_out,    o_result.flag_out);
            end
        end
        if (i_rst_n && start && !busy) begin
            pending_results.push_back(tod_predict(i_cmd));
        end
        if ((i_rst_n && start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic tod_pkg::t_cmd mk_cmd(input logic [3:0] f,
                                             input logic [5:0] ha, input logic [5:0] ma,
                                             input logic [5:0] sa, input logic [5:0] hb,
                                             input logic [5:0] mb, input logic [5:0] sb,
                                             input logic [31:0] n);
        tod_pkg::t_cmd c;
        c.func       = f;
        c.hour_a     = ha;
        c.minute_a   = ma;
        c.second_a   = sa;
        c.hour_b     = hb;
        c.minute_b   = mb;
        c.second_b   = sb;
        c.seconds_in = n;
        return c;
    endfunction

    // Random idle cycles; the command bus carries junk while start is low,
    // which the DUT must ignore.
    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            i_cmd <= {$urandom, $urandom, 8'($urandom)};
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Sends one item and returns at the edge where it is taken. The sender
    // runs in bursts: between bursts it idles a random number of cycles, and
    // every few bursts are long with no gap at all. Must be called at a
    // rising edge.
    task automatic send_item(input tod_pkg::t_cmd c);
        if (burst_left == 0) begin
            idle_for($urandom_range(0, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Holds the sender off until the pipeline has returned every result.
    task automatic wait_drained();
        start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Field limits: the last valid value and the first invalid one of each field,
    // plus all-zero and all-ones
    task automatic test_validate();
        send_item(mk_cmd(tod_pkg::FN_VALIDATE, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk_cmd(tod_pkg::FN_VALIDATE, 23, 59, 59, 0, 0, 0, 0));
        send_item(mk_cmd(tod_pkg::FN_VALIDATE, 24, 0, 0, 0, 0, 0, 0));
        send_item(mk_cmd(tod_pkg::FN_VALIDATE, 23, 60, 59, 0, 0, 0, 0));
        send_item(mk_cmd(tod_pkg::FN_VALIDATE, 23, 59, 60, 0, 0, 0, 0));
        send_item(mk_cmd(tod_pkg::FN_VALIDATE, 63, 63, 63, 63, 63, 63, 32'hFFFF_FFFF));
    endtask

    // to_seconds of the largest field values; from_seconds around a day boundary
    task automatic test_conversions();
        send_item(mk_cmd(tod_pkg::FN_TO_SECS, 63, 63, 63, 0, 0, 0, 0));
        send_item(mk_cmd(tod_pkg::FN_TO_SECS, 23, 59, 59, 0, 0, 0, 0));
        send_item(mk_cmd(tod_pkg::FN_FROM_SECS, 0, 0, 0, 0, 0, 0, SECS_PER_DAY - 1));
        send_item(mk_cmd(tod_pkg::FN_FROM_SECS, 0, 0, 0, 0, 0, 0, SECS_PER_DAY));
        send_item(mk_cmd(tod_pkg::FN_FROM_SECS, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    endtask

    // Wrap across midnight both ways; subtract amounts of a day or more
    task automatic test_add_sub();
        send_item(mk_cmd(tod_pkg::FN_ADD, 23, 59, 59, 0, 0, 0, 1));
        send_item(mk_cmd(tod_pkg::FN_ADD, 63, 63, 63, 0, 0, 0, 32'hFFFF_FFFF));
        send_item(mk_cmd(tod_pkg::FN_SUB, 0, 0, 0, 0, 0, 0, 1));
        send_item(mk_cmd(tod_pkg::FN_SUB, 12, 30, 0, 0, 0, 0, SECS_PER_DAY));
        send_item(mk_cmd(tod_pkg::FN_SUB, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    endtask

    // A before B, equal, A after B (adds a day), and A after B by more than
    // a day, which only out-of-range fields allow
    task automatic test_duration();
        send_item(mk_cmd(tod_pkg::FN_DURATION, 1, 2, 3, 22, 0, 0, 0));
        send_item(mk_cmd(tod_pkg::FN_DURATION, 5, 5, 5, 5, 5, 5, 0));
        send_item(mk_cmd(tod_pkg::FN_DURATION, 23, 0, 0, 1, 0, 0, 0));
        send_item(mk_cmd(tod_pkg::FN_DURATION, 63, 63, 63, 0, 0, 0, 0));
    endtask

    // Same seconds from different fields: eq/neq look at fields, lt/gt at seconds
    task automatic test_compares();
        send_item(mk_cmd(tod_pkg::FN_EQ, 0, 1, 0, 0, 0, 60, 0));
        send_item(mk_cmd(tod_pkg::FN_NEQ, 0, 1, 0, 0, 0, 60, 0));
        send_item(mk_cmd(tod_pkg::FN_LT, 0, 1, 0, 0, 0, 60, 0));
        send_item(mk_cmd(tod_pkg::FN_GT, 0, 1, 0, 0, 0, 60, 0));
        send_item(mk_cmd(tod_pkg::FN_EQ, 7, 8, 9, 7, 8, 9, 0));
        send_item(mk_cmd(tod_pkg::FN_LT, 0, 0, 0, 23, 59, 59, 0));
        send_item(mk_cmd(tod_pkg::FN_GT, 23, 59, 59, 0, 0, 0, 0));
    endtask

    // Undefined op codes must return all zeros, even with busy operands
    task automatic test_unknown_codes();
        for (int code = FN_LAST + 1; code <= FN_CODE_MAX; code++) begin
            send_item(mk_cmd(code[3:0], 63, 63, 63, 63, 63, 63, 32'hFFFF_FFFF));
        end
    endtask

    // ------------------------------------------------------------------
    // Random test
    // ------------------------------------------------------------------

    // Amount for from/add/sub: within a day, around whole days, just below 2^32, or anywhere
    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, SECS_PER_DAY - 1);
            1:       return SECS_PER_DAY * $urandom_range(0, 4) + $urandom_range(0, 4) - 2;
            2:       return 32'hFFFF_FFFF - $urandom_range(0, SECS_PER_DAY);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random();
        tod_pkg::t_cmd c;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            c = {$urandom, $urandom, 8'($urandom)};
            // most items use valid times; the rest keep the full 6-bit fields
            if ($urandom_range(0, 9) < 6) begin
                c.hour_a   = 6'($urandom_range(0, HOUR_LIMIT));
                c.minute_a = 6'($urandom_range(0, MIN_LIMIT));
                c.second_a = 6'($urandom_range(0, MIN_LIMIT));
                c.hour_b   = 6'($urandom_range(0, HOUR_LIMIT));
                c.minute_b = 6'($urandom_range(0, MIN_LIMIT));
                c.second_b = 6'($urandom_range(0, MIN_LIMIT));
            end
            // equal operands now and then, so eq/neq/duration see the tie
            if ($urandom_range(0, 7) == 0) begin
                c.hour_b   = c.hour_a;
                c.minute_b = c.minute_a;
                c.second_b = c.second_a;
            end
            c.func = ($urandom_range(0, 19) == 0) ?
                     4'($urandom_range(FN_LAST + 1, FN_CODE_MAX)) :
                     4'($urandom_range(tod_pkg::FN_VALIDATE, FN_LAST));
            if ($urandom_range(0, 1) == 0) begin
                c.seconds_in = pick_amount();
            end
            send_item(c);
            // one full drain midway through
            if (i == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        error_count  = 0;
        stall_cycles = 0;
        burst_left   = 0;
        start        = 1'b0;
        i_cmd        = '0;
        i_rst_n      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_validate();
        test_conversions();
        test_add_sub();
        test_duration();
        test_compares();
        test_unknown_codes();
        test_random();

        // let the pipeline empty, then watch a little longer for stray strobes
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
